/* sv/pgsd_pkg.sv */
`default_nettype none

package pgsd_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int NORM_W          = 16;
    localparam int LIMIT_W         = 20;
    localparam int LIMIT_SQ_W      = 2 * LIMIT_W;
    localparam int SAT_W           = 22;
    localparam int SQ_W            = 2 * SAT_W;
    localparam int D2_W            = SQ_W + 2;
    localparam int CFG_IDX_W       = 1;

    localparam logic [SAT_W-1:0] DIFF_SAT = SAT_W'(1) << (SAT_W - 1);

    localparam logic [LIMIT_W-1:0] GAP_LIMIT_RST     = LIMIT_W'(20000);
    localparam logic [LIMIT_W-1:0] SPACING_LIMIT_RST = LIMIT_W'(5000);
    localparam logic [LIMIT_SQ_W-1:0] GAP_SQ_RST     =
        LIMIT_SQ_W'(GAP_LIMIT_RST) * LIMIT_SQ_W'(GAP_LIMIT_RST);
    localparam logic [LIMIT_SQ_W-1:0] SPACING_SQ_RST =
        LIMIT_SQ_W'(SPACING_LIMIT_RST) * LIMIT_SQ_W'(SPACING_LIMIT_RST);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP     = 1'b0,
        CFG_SPACING = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [LIMIT_SQ_W-1:0] gap_sq;
        logic [LIMIT_SQ_W-1:0] spacing_sq;
    } t_limits;

endpackage

`default_nettype wire

/* sv/point_gap_split_spacing_decimate_core.sv */
// Point decimation with gap splitting.
// Input channel: i_in_valid / o_in_stall with one point per request (position,
// normal, slice start). Output channel: o_out_valid / i_out_stall with one kept
// point per request and its fragment start flag. Dropped points produce no
// output request.
// Config channel: i_cfg_valid / o_cfg_ready (always ready); index 0 gap limit,
// index 1 spacing limit. Write only while idle. Limits are stored squared.
// Pipeline: an accepted point goes into the input register, and a kept point
// then goes into the result register, which drives o_out_valid. Throughput:
// one point per cycle while the output is not stalled; the keep decision and
// the previous/kept point update are combinational between the two registers
// (two squared-distance units and their compares).
// Reset: clears both pipeline valids, previous and kept points to the origin,
// and the limits to 20000 um and 5000 um.
// Stall: a stalled result holds; the input register still takes a point while
// it is empty or the result register is free or being taken, so o_in_stall
// rises only with both registers full and the result stalled.
`default_nettype none

module point_gap_split_spacing_decimate_core #(
    parameter int COORD_WIDTH = pgsd_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [pgsd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [pgsd_pkg::LIMIT_W-1:0]         i_cfg_data,

    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]        i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_pos_z,
    input  wire logic signed [pgsd_pkg::NORM_W-1:0]   i_norm_x,
    input  wire logic signed [pgsd_pkg::NORM_W-1:0]   i_norm_y,
    input  wire logic signed [pgsd_pkg::NORM_W-1:0]   i_norm_z,
    input  wire logic                                 i_slice_start,

    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [COORD_WIDTH-1:0]             o_out_x,
    output logic signed [COORD_WIDTH-1:0]             o_out_y,
    output logic signed [COORD_WIDTH-1:0]             o_out_z,
    output logic signed [pgsd_pkg::NORM_W-1:0]        o_out_norm_x,
    output logic signed [pgsd_pkg::NORM_W-1:0]        o_out_norm_y,
    output logic signed [pgsd_pkg::NORM_W-1:0]        o_out_norm_z,
    output logic                                      o_fragment_start
);

    pgsd_pkg::t_limits                       limits;

    logic                                    r_in_valid;
    logic [2:0][COORD_WIDTH-1:0]             r_pos;
    logic [2:0][pgsd_pkg::NORM_W-1:0]        r_norm;
    logic                                    r_slice;

    logic [2:0][COORD_WIDTH-1:0]             r_prev;
    logic [2:0][COORD_WIDTH-1:0]             r_kept;

    logic                                    r_out_valid;
    logic [2:0][COORD_WIDTH-1:0]             r_out_pos;
    logic [2:0][pgsd_pkg::NORM_W-1:0]        r_out_norm;
    logic                                    r_out_frag;

    logic [pgsd_pkg::D2_W-1:0]               d2_prev;
    logic [pgsd_pkg::D2_W-1:0]               d2_kept;
    logic                                    adv;
    logic                                    in_acc;
    logic                                    fire;
    logic                                    gap_brk;
    logic                                    n_keep;
    logic                                    n_frag;

    pgsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (limits)
    );

    pgsd_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist_prev (
        .i_pt_a (r_prev),
        .i_pt_b (r_pos),
        .o_d2   (d2_prev)
    );

    pgsd_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist_kept (
        .i_pt_a (r_kept),
        .i_pt_b (r_pos),
        .o_d2   (d2_kept)
    );

    assign o_cfg_ready = 1'b1;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && adv;

    assign gap_brk = d2_prev > pgsd_pkg::D2_W'(limits.gap_sq);
    assign n_frag  = r_slice || gap_brk;
    assign n_keep  = n_frag || (d2_kept >= pgsd_pkg::D2_W'(limits.spacing_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || adv) begin
            r_in_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos   <= {i_pos_z, i_pos_y, i_pos_x};
            r_norm  <= {i_norm_z, i_norm_y, i_norm_x};
            r_slice <= i_slice_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_kept <= '0;
        end else if (fire) begin
            r_prev <= r_pos;
            if (n_keep) begin
                r_kept <= r_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_keep) begin
            r_out_pos  <= r_pos;
            r_out_norm <= r_norm;
            r_out_frag <= n_frag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_x          = r_out_pos[0];
    assign o_out_y          = r_out_pos[1];
    assign o_out_z          = r_out_pos[2];
    assign o_out_norm_x     = r_out_norm[0];
    assign o_out_norm_y     = r_out_norm[1];
    assign o_out_norm_z     = r_out_norm[2];
    assign o_fragment_start = r_out_frag;

endmodule

`default_nettype wire

/* sv/pgsd_cfg.sv */
`default_nettype none

module pgsd_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [pgsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pgsd_pkg::LIMIT_W-1:0]    i_cfg_data,
    output pgsd_pkg::t_limits                    o_limits
);

    pgsd_pkg::t_limits                    r_limits;
    logic [pgsd_pkg::LIMIT_SQ_W-1:0]      n_sq;

    // limits are held squared so the datapath only compares
    assign n_sq = pgsd_pkg::LIMIT_SQ_W'(i_cfg_data) * pgsd_pkg::LIMIT_SQ_W'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.gap_sq     <= pgsd_pkg::GAP_SQ_RST;
            r_limits.spacing_sq <= pgsd_pkg::SPACING_SQ_RST;
        end else if (i_cfg_valid) begin
            unique case (pgsd_pkg::t_cfg_reg'(i_cfg_index))
                pgsd_pkg::CFG_GAP:     r_limits.gap_sq     <= n_sq;
                pgsd_pkg::CFG_SPACING: r_limits.spacing_sq <= n_sq;
                default:               r_limits            <= r_limits;
            endcase
        end
    end

    assign o_limits = r_limits;

endmodule

`default_nettype wire

/* sv/pgsd_dist.sv */
`default_nettype none

module pgsd_dist #(
    parameter int COORD_WIDTH = pgsd_pkg::COORD_WIDTH_DEF
) (
    input  wire logic [2:0][COORD_WIDTH-1:0] i_pt_a,
    input  wire logic [2:0][COORD_WIDTH-1:0] i_pt_b,
    output logic [pgsd_pkg::D2_W-1:0]        o_d2
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int MW = (DW > pgsd_pkg::SAT_W) ? DW : pgsd_pkg::SAT_W;

    logic signed [2:0][DW-1:0]         diff;
    logic        [2:0][DW-1:0]         mag;
    logic        [2:0][MW-1:0]         mag_x;
    logic        [2:0][pgsd_pkg::SAT_W-1:0] sat;
    logic        [2:0][pgsd_pkg::SQ_W-1:0]  sq;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k]  = DW'({i_pt_a[k][COORD_WIDTH-1], i_pt_a[k]})
                     - DW'({i_pt_b[k][COORD_WIDTH-1], i_pt_b[k]});
            mag[k]   = diff[k][DW-1] ? DW'(-diff[k]) : diff[k];
            mag_x[k] = MW'(mag[k]);
            sat[k]   = (mag_x[k] > MW'(pgsd_pkg::DIFF_SAT)) ? pgsd_pkg::DIFF_SAT
                                                           : mag_x[k][pgsd_pkg::SAT_W-1:0];
            sq[k]    = pgsd_pkg::SQ_W'(sat[k]) * pgsd_pkg::SQ_W'(sat[k]);
        end
        o_d2 = pgsd_pkg::D2_W'(sq[0]) + pgsd_pkg::D2_W'(sq[1]) + pgsd_pkg::D2_W'(sq[2]);
    end

endmodule

`default_nettype wire

/* sv/pgsd_checker.sv */
`default_nettype none

module pgsd_checker #(
    parameter int COORD_WIDTH = pgsd_pkg::COORD_WIDTH_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          i_slice_start,
    input wire logic signed [COORD_WIDTH-1:0] i_pos_x,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic signed [COORD_WIDTH-1:0] o_out_x,
    input wire logic                          o_fragment_start
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_x)
                                       && $stable(o_fragment_start))
        else $error("stalled output request changed");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    a_slice_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_slice_start) ##1 !o_in_stall |=>
            o_out_valid && o_fragment_start && o_out_x == $past(i_pos_x, 2))
        else $error("slice start point not emitted as fragment start");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind point_gap_split_spacing_decimate_core pgsd_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_pgsd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_slice_start    (i_slice_start),
    .i_pos_x          (i_pos_x),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_x          (o_out_x),
    .o_fragment_start (o_fragment_start)
);

`default_nettype wire
